@@ rtl/des_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes and round helpers shared by the cipher modules.
// ---------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned ROUNDS = 16;

  localparam logic CFG_IDX_KEY = 1'b0;
  localparam logic CFG_IDX_DIR = 1'b1;

  typedef logic [63:0] block_t;
  typedef logic [55:0] cd_t;
  typedef logic [47:0] subkey_t;

  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
  } half_pair_t;

  typedef logic [7:0] pos_t;

  localparam pos_t TAB_IP [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam pos_t TAB_IP_INV [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam pos_t TAB_E [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam pos_t TAB_P [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam pos_t TAB_PC1 [56] = '{
    57,49,41,33,25,17,9,1, 58,50,42,34,26,18,10,2,
    59,51,43,35,27,19,11,3, 60,52,44,36,
    63,55,47,39,31,23,15,7, 62,54,46,38,30,22,14,6,
    61,53,45,37,29,21,13,5, 28,20,12,4};

  localparam pos_t TAB_PC2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  // Cumulative left rotation of C and D after each round.
  localparam logic [4:0] TAB_ROT_SUM [16] = '{
    1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};

  localparam logic [3:0] TAB_SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic block_t perm_ip(input block_t v);
    block_t o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64 - int'(TAB_IP[i])];
    return o;
  endfunction

  function automatic block_t perm_ip_inv(input block_t v);
    block_t o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64 - int'(TAB_IP_INV[i])];
    return o;
  endfunction

  function automatic cd_t perm_pc1(input block_t v);
    cd_t o;
    for (int i = 0; i < 56; i++) o[55-i] = v[64 - int'(TAB_PC1[i])];
    return o;
  endfunction

  function automatic subkey_t perm_pc2(input cd_t v);
    subkey_t o;
    for (int i = 0; i < 48; i++) o[47-i] = v[56 - int'(TAB_PC2[i])];
    return o;
  endfunction

  // Both 28-bit halves rotated left by n bits.
  function automatic cd_t rot_cd(input cd_t v, input int unsigned n);
    logic [55:0] cc;
    logic [55:0] dd;
    cc = {v[55:28], v[55:28]} << n;
    dd = {v[27:0], v[27:0]} << n;
    return {cc[55:28], dd[55:28]};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
    logic [47:0] x;
    logic [31:0] f;
    logic [31:0] o;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TAB_E[i])];
    x = x ^ k;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      f[31-4*b -: 4] = TAB_SBOX[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) o[31-i] = f[32 - int'(TAB_P[i])];
    return o;
  endfunction

endpackage
`default_nettype wire

@@ rtl/des_keysched.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// DES key schedule
// Registers the sixteen subkeys of the configured key, in round order for
// encryption and reversed for decryption.
// ---------------------------------------------------------------------------
module des_keysched
  import des_pkg::*;
(
  input  wire logic    clk,
  input  wire block_t  key,
  input  wire logic    decrypt,
  output subkey_t      subkey [ROUNDS]
);

  cd_t     cd0;
  subkey_t sub_nxt [ROUNDS];
  subkey_t sub_r   [ROUNDS];

  always_comb begin
    cd0 = perm_pc1(key);
    for (int i = 0; i < ROUNDS; i++) begin
      // Stage i takes the subkey of round i, or of round 15 - i when decrypting.
      sub_nxt[i] =
        perm_pc2(rot_cd(cd0, int'(TAB_ROT_SUM[decrypt ? (ROUNDS - 1 - i) : i])));
    end
  end

  always_ff @(posedge clk) begin
    sub_r <= sub_nxt;
  end

  assign subkey = sub_r;

endmodule
`default_nettype wire

@@ rtl/des_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// DES round stage
// One Feistel round with its pipeline register; holds while stalled.
// ---------------------------------------------------------------------------
module des_round
  import des_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic       in_v,
  input  wire half_pair_t in_d,
  input  wire subkey_t    key,
  output logic            out_v,
  output half_pair_t      out_d
);

  logic       v_r;
  half_pair_t d_r;
  half_pair_t d_nxt;

  assign d_nxt.l = in_d.r;
  assign d_nxt.r = in_d.l ^ feistel(in_d.r, key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule
`default_nettype wire

@@ rtl/des_block_cipher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// DES block cipher
// Pipelined DES engine, one 64-bit block per cycle in ECB fashion while the output is not stalled.
// ---------------------------------------------------------------------------
// Use: write cfg index 0 with the 64-bit key and index 1 with the direction
// (0 encrypt, 1 decrypt) while the pipe is empty; the key schedule then
// registers the subkeys from the stored key and direction. Blocks enter on
// in_valid/in_stall and leave on out_valid/out_stall. The pipe is an input
// stage holding the initial permutation, sixteen round stages and an output
// stage. One block is accepted every cycle while the output is not stalled;
// each round stage holds one Feistel round. The whole pipe advances
// together: while out_stall holds a waiting result, the pipe freezes and
// in_stall rises, so nothing is lost or repeated. Empty stages are not
// compressed; in_stall only rises when the output stage is full and
// stalled. Reset clears all valid bits, the key to zero and the direction
// to encrypt.
// ---------------------------------------------------------------------------
module des_block_cipher
  import des_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_text_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_result_block
);

  block_t     key_r;
  logic       dec_r;
  subkey_t    subkey [ROUNDS];
  logic       adv;
  logic       v0_r;
  half_pair_t d0_r;
  logic       sv   [ROUNDS+1];
  half_pair_t sd   [ROUNDS+1];
  logic       ov_r;
  block_t     od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      dec_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_KEY: key_r <= cfg_data;
        CFG_IDX_DIR: dec_r <= cfg_data[0];
        default:     key_r <= key_r;
      endcase
    end
  end

  des_keysched u_ks (.clk(clk), .key(key_r), .decrypt(dec_r), .subkey(subkey));

  assign adv      = !(ov_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_r <= perm_ip(in_text_block);
    end
  end

  assign sv[0] = v0_r;
  assign sd[0] = d0_r;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
    des_round u_rnd (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_v(sv[g]), .in_d(sd[g]), .key(subkey[g]),
      .out_v(sv[g+1]), .out_d(sd[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= sv[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      od_r <= perm_ip_inv({sd[ROUNDS].r, sd[ROUNDS].l});
    end
  end

  assign out_valid        = ov_r;
  assign out_result_block = od_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with output empty");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_block))
    else $error("stalled result changed");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v0_r) && $stable(sv[ROUNDS]))
    else $error("pipe moved while stalled");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DES block cipher testbench
// Drives 64-bit blocks through the cipher under several keys and both
// directions, with random idle and stall phases, and checks every result
// against a bit-level DES model in a small scoreboard.
// ---------------------------------------------------------------------------

class des_scoreboard;
  logic [63:0] key_q;
  logic        dec_q;
  logic [63:0] pending_blocks[$];
  int          errors;

  function new();
    key_q = '0;
    dec_q = 1'b0;
    errors = 0;
  endfunction

  // Pick bits from a w-bit value; positions are numbered from the MSB as 1.
  function automatic logic [63:0] pick(logic [63:0] src, int w, des_pkg::pos_t tab[],
                                       int cnt);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < cnt; i++) acc = {acc[62:0], src[w - int'(tab[i])]};
    return acc;
  endfunction

  function automatic logic [27:0] rot28(logic [27:0] v, int n);
    for (int k = 0; k < n; k++) v = {v[26:0], v[27]};
    return v;
  endfunction

  function automatic logic [31:0] round_f(logic [31:0] r, logic [47:0] sk);
    logic [47:0] x;
    logic [31:0] f;
    logic [5:0]  six;
    x = 48'(pick({32'b0, r}, 32, des_pkg::TAB_E, 48)) ^ sk;
    f = '0;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      f = {f[27:0], des_pkg::TAB_SBOX[b][{six[5], six[0]} * 16 + six[4:1]]};
    end
    return 32'(pick({32'b0, f}, 32, des_pkg::TAB_P, 32));
  endfunction

  function automatic logic [63:0] cipher(logic [63:0] blk);
    logic [47:0] sub[16];
    logic [55:0] cd;
    logic [27:0] c, d;
    logic [63:0] m;
    logic [31:0] l, r, t;
    int shifts[16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    cd = 56'(pick(key_q, 64, des_pkg::TAB_PC1, 56));
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      c = rot28(c, shifts[i]);
      d = rot28(d, shifts[i]);
      sub[i] = 48'(pick({8'b0, c, d}, 56, des_pkg::TAB_PC2, 48));
    end
    m = pick(blk, 64, des_pkg::TAB_IP, 64);
    l = m[63:32];
    r = m[31:0];
    for (int i = 0; i < 16; i++) begin
      t = r;
      r = l ^ round_f(r, sub[dec_q ? 15 - i : i]);
      l = t;
    end
    return pick({r, l}, 64, des_pkg::TAB_IP_INV, 64);
  endfunction

  function void note_block(logic [63:0] blk);
    pending_blocks = {pending_blocks, cipher(blk)};
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_result(logic [63:0] got);
    logic [63:0] want;
    if (pending_blocks.size() == 0) begin
      report($sformatf("result %h with no transaction pending", got));
      return;
    end
    want = pending_blocks.pop_front();
    if (got !== want) begin
      report($sformatf("result_block got %h want %h", got, want));
    end
  endtask
endclass

module tb_top;
  import des_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_IDX_KEY;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_text_block = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_block;

  des_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  des_block_cipher dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: a long hold-off takes priority over the random stall rate.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_result_block);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_cfg(logic idx, logic [63:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_IDX_KEY) sb.key_q = val;
    else sb.dec_q = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // The valid line stays high after a transaction unless the sender idles,
  // so back-to-back blocks see a single assignment per edge.
  task automatic send_block(logic [63:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_block <= blk;
    do @(posedge clk); while (in_stall);
    sb.note_block(blk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  logic [63:0] keys[6] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1334_5779_9BBC_DFF1,
                           64'h0101_0101_0101_0101, 64'h01FE_01FE_01FE_01FE, 64'h0};
  int idle_phase[4] = '{0, 85, 0, 22};
  int stall_phase[4] = '{0, 0, 85, 22};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: the classic known-answer block, extremes and walking ones.
    send_block(64'h0123_4567_89AB_CDEF);
    send_block(64'h0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    for (int k = 1; k < 5; k++) begin
      write_cfg(CFG_IDX_KEY, keys[k]);
      for (int dir = 0; dir < 2; dir++) begin
        write_cfg(CFG_IDX_DIR, 64'(dir));
        send_block(64'h0123_4567_89AB_CDEF);
        send_block(64'h85E8_1354_0F0A_B405);
        send_block(64'h1 << (k * 13));
        drain();
      end
    end

    // Receiver holds off while blocks keep coming, so the pipe fills up.
    hold_cycles = 60;
    for (int i = 0; i < 40; i++) send_block(rand64());
    drain();

    for (int p = 0; p < 16; p++) begin
      send_idle_pct = idle_phase[p % 4];
      recv_stall_pct = stall_phase[p % 4];
      write_cfg(CFG_IDX_KEY, (p == 15) ? keys[1] : rand64());
      write_cfg(CFG_IDX_DIR, 64'($urandom_range(1)));
      for (int i = 0; i < 36; i++) send_block(rand64());
      drain();
    end

    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
